@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the matcher checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define MSBM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also watches the reset cycles
`define MSBM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/msbm_pkg.sv @@
// ---------------------------------------------------------------------------
// msbm_pkg
// Types, constants and codes shared by the signature byte matcher.
// ---------------------------------------------------------------------------
package msbm_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int WINDOW_LEN_DEF  = 12;
  localparam int SIG_SLOTS       = 12;
  localparam int LEN_W           = 4;
  localparam int MASK_W          = 12;
  localparam int CFG_W           = 7;
  localparam int ENTRY_W         = 6;
  localparam int OFFSET_W        = 32;

  localparam logic [1:0] OP_SCAN     = 2'd0;
  localparam logic [1:0] OP_SIG_BYTE = 2'd1;
  localparam logic [1:0] OP_HEADER   = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic               sig_we;
    logic               hdr_we;
    logic [ENTRY_W-1:0] entry;
    logic [3:0]         pos;
    logic [7:0]         data;
    logic [LEN_W-1:0]   len;
    logic [MASK_W-1:0]  mask;
  } tbl_wr_t;

  typedef struct packed {
    logic                        hdr_valid;
    logic [LEN_W-1:0]            len;
    logic [MASK_W-1:0]           mask;
    logic [SIG_SLOTS-1:0][7:0]   sig;
  } tbl_rd_t;

  typedef struct packed {
    logic       shift;
    logic       start;
    logic [7:0] data;
  } win_ctl_t;

endpackage

@@ rtl/core/msbm_if.sv @@
// ---------------------------------------------------------------------------
// msbm interfaces
// Valid/ready channels for input items and result words.
// ---------------------------------------------------------------------------
interface msbm_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic        buffer_start;
  logic [7:0]  data_byte;
  logic [5:0]  entry_index;
  logic [3:0]  byte_position;
  logic [3:0]  entry_length;
  logic [11:0] care_mask;

  modport source (
    output valid, operation, buffer_start, data_byte, entry_index,
           byte_position, entry_length, care_mask,
    input  ready
  );
  modport sink (
    input  valid, operation, buffer_start, data_byte, entry_index,
           byte_position, entry_length, care_mask,
    output ready
  );
endinterface

interface msbm_result_if;
  logic        valid;
  logic        ready;
  logic        result_valid;
  logic        matched;
  logic [5:0]  match_entry;
  logic [31:0] window_offset;

  modport source (
    output valid, result_valid, matched, match_entry, window_offset,
    input  ready
  );
  modport sink (
    input  valid, result_valid, matched, match_entry, window_offset,
    output ready
  );
endinterface

@@ rtl/core/masked_signature_byte_matcher.sv @@
// ---------------------------------------------------------------------------
// masked_signature_byte_matcher
// Byte stream scanner against a table of masked signatures.
// ---------------------------------------------------------------------------
//  channel   kind          handshake            word
//  item      in, stream    valid/ready          operation and table or scan data
//  result    out, stream   valid/ready          one result word per item
//  cfg       in, register  cfg_wr_en            entries_in_use
//
//  Table writes, scan bytes that leave the window short and scan bytes with
//  no entries in use load their result word into the output register. A scan
//  byte with a full window walks the table memory read port one row per cycle,
//  up to min(entries_in_use, MAX_ENTRIES) rows, ending early at the first match.
//  Reset is synchronous; header valid bits clear at once, no clearing pass.
//  A result word waits in the output register; the next item is taken once
//  that register is free or being drained.
// ---------------------------------------------------------------------------
module masked_signature_byte_matcher #(
  parameter int MAX_ENTRIES = msbm_pkg::MAX_ENTRIES_DEF,
  parameter int WINDOW_LEN  = msbm_pkg::WINDOW_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [msbm_pkg::CFG_W-1:0] cfg_wr_data,
  msbm_item_if.sink                  item,
  msbm_result_if.source              result
);
  import msbm_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES > 1 ? MAX_ENTRIES : 2);

  tbl_wr_t                    tbl_wr;
  tbl_rd_t                    tbl_rd;
  win_ctl_t                   win_ctl;
  logic [AW-1:0]              rd_addr;
  logic [WINDOW_LEN-1:0][7:0] win;
  logic                       win_full_next;
  logic [OFFSET_W-1:0]        offset_next;

  msbm_sig_table #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .wr      (tbl_wr),
    .rd_addr (rd_addr),
    .rd      (tbl_rd)
  );

  msbm_window #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_window (
    .clk         (clk),
    .rst         (rst),
    .ctl         (win_ctl),
    .win         (win),
    .full_next   (win_full_next),
    .offset_next (offset_next)
  );

  msbm_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .WINDOW_LEN  (WINDOW_LEN)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .item          (item),
    .result        (result),
    .tbl_wr        (tbl_wr),
    .rd_addr       (rd_addr),
    .tbl_rd        (tbl_rd),
    .win_ctl       (win_ctl),
    .win           (win),
    .win_full_next (win_full_next),
    .offset_next   (offset_next)
  );

endmodule

@@ rtl/core/msbm_sig_table.sv @@
// ---------------------------------------------------------------------------
// msbm_sig_table
// Signature row memory and entry header memory, one row read per cycle.
// ---------------------------------------------------------------------------
module msbm_sig_table #(
  parameter int MAX_ENTRIES = msbm_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                                    clk,
  input  logic                                                    rst,
  input  msbm_pkg::tbl_wr_t                                       wr,
  input  logic [$clog2(MAX_ENTRIES > 1 ? MAX_ENTRIES : 2)-1:0]    rd_addr,
  output msbm_pkg::tbl_rd_t                                       rd
);
  import msbm_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES > 1 ? MAX_ENTRIES : 2);

  logic [SIG_SLOTS-1:0][7:0]    sig_mem [MAX_ENTRIES];
  logic [LEN_W+MASK_W-1:0]      hdr_mem [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]       hdr_valid;
  logic [AW-1:0]                waddr;
  logic                         entry_ok;
  logic                         sig_write;
  logic                         hdr_write;
  logic [LEN_W-1:0]             len_clamped;

  always_comb begin
    waddr       = AW'(wr.entry);
    entry_ok    = (32'(wr.entry) < MAX_ENTRIES);
    sig_write   = wr.sig_we && entry_ok && (32'(wr.pos) < SIG_SLOTS);
    hdr_write   = wr.hdr_we && entry_ok;
    len_clamped = (32'(wr.len) > SIG_SLOTS) ? LEN_W'(SIG_SLOTS) : wr.len;
  end

  always_ff @(posedge clk) begin
    if (sig_write) begin
      sig_mem[waddr][wr.pos] <= wr.data;
    end
    if (hdr_write) begin
      hdr_mem[waddr] <= {len_clamped, wr.mask};
    end
    rd.sig       <= sig_mem[rd_addr];
    rd.len       <= hdr_mem[rd_addr][LEN_W+MASK_W-1:MASK_W];
    rd.mask      <= hdr_mem[rd_addr][MASK_W-1:0];
    rd.hdr_valid <= hdr_valid[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_valid <= '0;
    end else begin
      if (hdr_write) begin
        hdr_valid[waddr] <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/msbm_window.sv @@
// ---------------------------------------------------------------------------
// msbm_window
// Scan window shift line and saturating stream byte count.
// ---------------------------------------------------------------------------
module msbm_window #(
  parameter int WINDOW_LEN = msbm_pkg::WINDOW_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  msbm_pkg::win_ctl_t                  ctl,
  output logic [WINDOW_LEN-1:0][7:0]          win,
  output logic                                full_next,
  output logic [msbm_pkg::OFFSET_W-1:0]       offset_next
);
  import msbm_pkg::*;

  logic [OFFSET_W-1:0]        seen;
  logic [OFFSET_W-1:0]        seen_next;
  logic [WINDOW_LEN-1:0][7:0] win_next;

  always_comb begin
    if (ctl.start) begin
      seen_next = OFFSET_W'(1);
    end else if (seen == {OFFSET_W{1'b1}}) begin
      seen_next = seen;
    end else begin
      seen_next = seen + OFFSET_W'(1);
    end
    for (int i = 0; i < WINDOW_LEN - 1; i++) begin
      win_next[i] = ctl.start ? 8'h00 : win[i+1];
    end
    win_next[WINDOW_LEN-1] = ctl.data;
    full_next   = (seen_next >= OFFSET_W'(WINDOW_LEN));
    offset_next = seen_next - OFFSET_W'(WINDOW_LEN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win  <= '0;
      seen <= '0;
    end else if (ctl.shift) begin
      win  <= win_next;
      seen <= seen_next;
    end
  end

endmodule

@@ rtl/core/msbm_ctrl.sv @@
// ---------------------------------------------------------------------------
// msbm_ctrl
// Item handshake, table walk sequencer, entry compare and result register.
// ---------------------------------------------------------------------------
module msbm_ctrl #(
  parameter int MAX_ENTRIES = msbm_pkg::MAX_ENTRIES_DEF,
  parameter int WINDOW_LEN  = msbm_pkg::WINDOW_LEN_DEF
) (
  input  logic                                                    clk,
  input  logic                                                    rst,
  input  logic                                                    cfg_wr_en,
  input  logic [msbm_pkg::CFG_W-1:0]                              cfg_wr_data,
  msbm_item_if.sink                                               item,
  msbm_result_if.source                                           result,
  output msbm_pkg::tbl_wr_t                                       tbl_wr,
  output logic [$clog2(MAX_ENTRIES > 1 ? MAX_ENTRIES : 2)-1:0]    rd_addr,
  input  msbm_pkg::tbl_rd_t                                       tbl_rd,
  output msbm_pkg::win_ctl_t                                      win_ctl,
  input  logic [WINDOW_LEN-1:0][7:0]                              win,
  input  logic                                                    win_full_next,
  input  logic [msbm_pkg::OFFSET_W-1:0]                           offset_next
);
  import msbm_pkg::*;

  localparam int AW      = $clog2(MAX_ENTRIES > 1 ? MAX_ENTRIES : 2);
  localparam int CW      = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_LEN = (WINDOW_LEN < SIG_SLOTS) ? WINDOW_LEN : SIG_SLOTS;

  state_t              state;
  state_t              state_next;
  logic [CFG_W-1:0]    entries_in_use;
  logic [CW-1:0]       count_eff;
  logic [CW-1:0]       iss;
  logic [AW-1:0]       cmp_idx;
  logic                cmp_v;
  logic [OFFSET_W-1:0] offset_hold;
  logic                accept;
  logic                is_scan;
  logic                start_scan;
  logic                load_now;
  logic                issue;
  logic                hit;
  logic                last;
  logic                finish;
  logic                out_valid;
  logic                out_result_valid;
  logic                out_matched;
  logic [ENTRY_W-1:0]  out_match_entry;
  logic [OFFSET_W-1:0] out_window_offset;

  always_comb begin
    count_eff  = (32'(entries_in_use) > MAX_ENTRIES) ? CW'(MAX_ENTRIES)
                                                     : CW'(entries_in_use);
    accept     = item.valid && item.ready;
    is_scan    = (item.operation == OP_SCAN);
    start_scan = accept && is_scan && win_full_next && (count_eff != '0);
    load_now   = accept && !start_scan;
    issue      = (state == ST_SCAN) && (iss != count_eff);
    last       = cmp_v && ((CW'(cmp_idx) + CW'(1)) == count_eff);
    finish     = (state == ST_SCAN) && cmp_v && (hit || last);
  end

  always_comb begin
    hit = tbl_rd.hdr_valid && (tbl_rd.len != '0) && (tbl_rd.mask != '0);
    for (int j = 0; j < CMP_LEN; j++) begin
      if (tbl_rd.mask[j] && (j < int'(tbl_rd.len)) && (tbl_rd.sig[j] != win[j])) begin
        hit = 1'b0;
      end
    end
  end

  always_comb begin
    case (state)
      ST_IDLE: begin
        state_next = start_scan ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        state_next = finish ? ST_IDLE : ST_SCAN;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    item.ready     = (state == ST_IDLE) && (!out_valid || result.ready);
    rd_addr        = iss[AW-1:0];
    tbl_wr.sig_we  = accept && (item.operation == OP_SIG_BYTE);
    tbl_wr.hdr_we  = accept && (item.operation == OP_HEADER);
    tbl_wr.entry   = item.entry_index;
    tbl_wr.pos     = item.byte_position;
    tbl_wr.data    = item.data_byte;
    tbl_wr.len     = item.entry_length;
    tbl_wr.mask    = item.care_mask;
    win_ctl.shift  = accept && is_scan;
    win_ctl.start  = item.buffer_start;
    win_ctl.data   = item.data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      entries_in_use <= '0;
      iss            <= '0;
      cmp_v          <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        entries_in_use <= cfg_wr_data;
      end
      if (start_scan) begin
        iss <= '0;
      end else if (issue) begin
        iss <= iss + CW'(1);
      end
      cmp_v <= issue;
      if (load_now || finish) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= iss[AW-1:0];
    if (start_scan) begin
      offset_hold <= offset_next;
    end
    if (load_now) begin
      out_result_valid  <= is_scan && win_full_next;
      out_matched       <= 1'b0;
      out_match_entry   <= '0;
      out_window_offset <= (is_scan && win_full_next) ? offset_next : '0;
    end else if (finish) begin
      out_result_valid  <= 1'b1;
      out_matched       <= hit;
      out_match_entry   <= hit ? ENTRY_W'(cmp_idx) : '0;
      out_window_offset <= offset_hold;
    end
  end

  assign result.valid         = out_valid;
  assign result.result_valid  = out_result_valid;
  assign result.matched       = out_matched;
  assign result.match_entry   = out_match_entry;
  assign result.window_offset = out_window_offset;

endmodule

@@ rtl/core/msbm_checker.sv @@
// ---------------------------------------------------------------------------
// msbm_checker
// Port level checks on the matcher, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module msbm_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic [1:0]  item_operation,
  input logic        res_valid,
  input logic        res_ready,
  input logic        res_result_valid,
  input logic        res_matched,
  input logic [5:0]  res_match_entry,
  input logic [31:0] res_window_offset
);
  import msbm_pkg::*;

  `MSBM_ASSERT(a_result_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(res_result_valid) && $stable(res_matched) && $stable(res_match_entry) && $stable(res_window_offset), "result word changed while stalled")
  `MSBM_ASSERT(a_empty_result, clk, rst, res_valid && !res_result_valid |-> !res_matched && res_match_entry == 6'd0 && res_window_offset == 32'd0, "empty result word carries data")
  `MSBM_ASSERT(a_write_result, clk, rst, item_valid && item_ready && item_operation != OP_SCAN |=> res_valid && !res_result_valid, "table write gave no empty result word")
  `MSBM_ASSERT_ALWAYS(a_reset_clear, clk, rst |=> !res_valid, "result word present after reset")

endmodule

bind masked_signature_byte_matcher msbm_checker u_msbm_checker (
  .clk               (clk),
  .rst               (rst),
  .item_valid        (item.valid),
  .item_ready        (item.ready),
  .item_operation    (item.operation),
  .res_valid         (result.valid),
  .res_ready         (result.ready),
  .res_result_valid  (result.result_valid),
  .res_matched       (result.matched),
  .res_match_entry   (result.match_entry),
  .res_window_offset (result.window_offset)
);
